// ----- sv/cross_average_smudge_filter_core_defines.svh -----
// Assertion macros used by the checker file of the cross average smudge filter.
`ifndef CROSS_AVERAGE_SMUDGE_FILTER_CORE_DEFINES_SVH
`define CROSS_AVERAGE_SMUDGE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is asserted.
`define CASF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is asserted.
`define CASF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/casf_pkg.sv -----
// Package with the shared constants, types and register codes of the smudge filter.
package casf_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int DIM_W     = 12;
	localparam int CMP_W     = ((DIM_W > ADDR_W) ? DIM_W : ADDR_W) + 1;
	localparam int MIN_DIM   = 3;

	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam int PIX_W  = CH_W * NUM_CH;
	localparam int SUM_W  = CH_W + 3;

	// Divide by five as a multiply by 1639 / 8192, exact for sums up to 1275.
	localparam int DIV5_MUL   = 1639;
	localparam int DIV5_SHIFT = 13;
	localparam int PROD_W     = SUM_W + 11;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		pix_t res;
		pix_t cur;
		logic last_row;
		logic row_end;
	} q_entry_t;

endpackage

// ----- sv/casf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module casf_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// A read and a write of the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/casf_front.sv -----
// Front end: position counters, line stores, five-point sums and result selection.
module casf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  casf_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_red,
	input  logic [7:0]        in_green,
	input  logic [7:0]        in_blue,
	input  logic [7:0]        in_alpha,
	input  logic              pop,
	output logic              push,
	output casf_pkg::q_entry_t push_entry
);
	import casf_pkg::*;

	function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(s) * PROD_W'(DIV5_MUL);
		return prod[DIV5_SHIFT +: CH_W];
	endfunction

	logic [ADDR_W-1:0] col_q;
	logic [DIM_W-1:0]  row_q;
	logic [QCNT_W-1:0] credits_q;

	logic [CMP_W-1:0]  fw_ext;
	logic [ADDR_W-1:0] wlast;
	logic [DIM_W-1:0]  hlast;
	logic              row_end;
	logic              last_row;
	logic              accept;
	logic              drop;
	pix_t              cur_pix;

	pix_t centre;
	pix_t up;
	pix_t right;

	logic              valid_s1;
	pix_t              cur_s1;
	logic [ADDR_W-1:0] col_s1;
	logic              has_res_s1;
	logic              pass_s1;
	logic              last_row_s1;
	logic              row_end_s1;
	pix_t              left_q;

	logic [NUM_CH-1:0][SUM_W-1:0] sum_c;

	logic                         valid_s2;
	logic [NUM_CH-1:0][SUM_W-1:0] sum_s2;
	pix_t                         centre_s2;
	pix_t                         cur_s2;
	logic                         has_res_s2;
	logic                         pass_s2;
	logic                         last_row_s2;
	logic                         row_end_s2;
	pix_t                         avg_pix;

	// Saturate the configured frame size into its working range.
	assign fw_ext = CMP_W'(cfg.frame_width);

	always_comb begin
		if (fw_ext < CMP_W'(MIN_DIM)) begin
			wlast = ADDR_W'(MIN_DIM - 1);
		end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
			wlast = ADDR_W'(MAX_WIDTH - 1);
		end else begin
			wlast = ADDR_W'(fw_ext - CMP_W'(1));
		end
		if (cfg.frame_height < DIM_W'(MIN_DIM)) begin
			hlast = DIM_W'(MIN_DIM - 1);
		end else begin
			hlast = cfg.frame_height - DIM_W'(1);
		end
	end

	assign row_end  = (col_q >= wlast);
	assign last_row = (row_q >= hlast);
	assign in_stall = (credits_q >= QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign cur_pix  = {in_alpha, in_blue, in_green, in_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			credits_q <= '0;
		end else begin
			credits_q <= credits_q + QCNT_W'(accept) - QCNT_W'(pop) - QCNT_W'(drop);
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + ADDR_W'(1);
				end
			end
		end
	end

	// Two copies of the middle row give the centre and right neighbors in the same cycle.
	casf_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_centre (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cur_pix),
		.re    (accept),
		.raddr (col_q),
		.rdata (centre)
	);

	casf_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_right (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cur_pix),
		.re    (accept),
		.raddr (col_q + ADDR_W'(1)),
		.rdata (right)
	);

	// The old middle pixel moves up once it has been read.
	casf_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (centre),
		.re    (accept),
		.raddr (col_q),
		.rdata (up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			left_q   <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				left_q <= centre;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur_pix;
			col_s1      <= col_q;
			has_res_s1  <= (row_q != '0);
			pass_s1     <= (row_q == DIM_W'(1)) || (col_q == '0) || row_end;
			last_row_s1 <= last_row;
			row_end_s1  <= row_end;
		end
		if (valid_s1) begin
			sum_s2      <= sum_c;
			centre_s2   <= centre;
			cur_s2      <= cur_s1;
			has_res_s2  <= has_res_s1;
			pass_s2     <= pass_s1;
			last_row_s2 <= last_row_s1;
			row_end_s2  <= row_end_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			sum_c[k] = SUM_W'(centre[k*CH_W +: CH_W]) + SUM_W'(up[k*CH_W +: CH_W])
				+ SUM_W'(cur_s1[k*CH_W +: CH_W]) + SUM_W'(left_q[k*CH_W +: CH_W])
				+ SUM_W'(right[k*CH_W +: CH_W]);
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			avg_pix[k*CH_W +: CH_W] = div5(sum_s2[k]);
		end
	end

	// Items of the first row produce nothing and give their credit back here.
	assign push = valid_s2 && has_res_s2;
	assign drop = valid_s2 && !has_res_s2;

	assign push_entry.res      = pass_s2 ? centre_s2 : avg_pix;
	assign push_entry.cur      = cur_s2;
	assign push_entry.last_row = last_row_s2;
	assign push_entry.row_end  = row_end_s2;

endmodule

// ----- sv/casf_queue.sv -----
// Short queue of classified items between the front end and the back end.
module casf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  casf_pkg::q_entry_t push_entry,
	input  logic               pop,
	output casf_pkg::q_entry_t head,
	output logic               empty
);
	import casf_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);

endmodule

// ----- sv/casf_back.sv -----
// Back end: expands queued items into one or two results and holds the output register.
module casf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  casf_pkg::q_entry_t head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_alpha,
	output logic               run_end,
	output logic               frame_end
);
	import casf_pkg::*;

	logic out_valid_q;
	logic phase_q;
	pix_t out_pix_q;
	logic run_end_q;
	logic frame_end_q;

	logic load;
	pix_t nxt_pix;
	logic nxt_run_end;
	logic nxt_frame_end;

	assign load = !out_valid_q || !out_stall;

	// On the last row the result for the pixel above goes out first, then the input itself.
	always_comb begin
		pop           = 1'b0;
		nxt_pix       = head.res;
		nxt_run_end   = 1'b1;
		nxt_frame_end = 1'b0;
		if (load && !empty) begin
			if (head.last_row && !phase_q) begin
				nxt_run_end = 1'b0;
			end else if (head.last_row) begin
				nxt_pix       = head.cur;
				nxt_frame_end = head.row_end;
				pop           = 1'b1;
			end else begin
				pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				phase_q <= head.last_row && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_pix_q   <= nxt_pix;
			run_end_q   <= nxt_run_end;
			frame_end_q <= nxt_frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_pix_q[0*CH_W +: CH_W];
	assign out_green = out_pix_q[1*CH_W +: CH_W];
	assign out_blue  = out_pix_q[2*CH_W +: CH_W];
	assign out_alpha = out_pix_q[3*CH_W +: CH_W];
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

endmodule

// ----- sv/cross_average_smudge_filter_core.sv -----
// The first result of an accepted item passes stage 1, stage 2, the queue and the output register.
// Throughput: one item per cycle while out_stall is low; an item of the last row holds
// up the items behind it, since it yields two results through the single output register.
// Credits for four items in flight cover the loop from accept through the queue to output load.
// Reset clears counters, queue and output valid and loads 640 x 480; the line stores
// are not cleared and hold undefined data until a first row has been written.
module cross_average_smudge_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [casf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [casf_pkg::DIM_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	input  logic [7:0]                      in_alpha,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic [7:0]                      out_alpha,
	output logic                            run_end,
	output logic                            frame_end
);
	import casf_pkg::*;

	// Configuration registers. The saturation into the working range happens in
	// the front end, so the registers keep exactly what was written.
	cfg_t cfg_q;

	// Front end to queue, queue to back end.
	logic     push;
	q_entry_t push_entry;
	q_entry_t head;
	logic     empty;
	logic     pop;

	// Writes are always taken; the user must keep the block idle whenever they arrive (unchecked).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data;
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data;
				end
			endcase
		end
	end

	// The front end takes one pixel per cycle while it holds a free credit. It reads
	// the centre, right and upper neighbors from the line stores, writes the new row
	// back, forms the five-point sums and the divide by five, and classifies the item
	// as border or interior, and as last row or not.
	casf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.in_alpha   (in_alpha),
		.pop        (pop),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue lets the back end stall on the output without freezing the front
	// end's pipeline; the credit count in the front end keeps it from overflowing.
	casf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	// The back end turns a queued item into its results: one for an ordinary row,
	// two for the last row, where the input pixel follows the pixel above it.
	casf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

endmodule

// ----- sv/casf_checker.sv -----
// Port-level checker of the smudge filter and its bind to the top level.
`include "cross_average_smudge_filter_core_defines.svh"

module casf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [casf_pkg::CH_W-1:0] out_red,
	input logic [casf_pkg::CH_W-1:0] out_green,
	input logic [casf_pkg::CH_W-1:0] out_blue,
	input logic [casf_pkg::CH_W-1:0] out_alpha,
	input logic                      run_end,
	input logic                      frame_end
);
	import casf_pkg::*;

	// Every field of the result item, gathered so that one check covers them all.
	logic [NUM_CH*CH_W+1:0] out_payload;

	assign out_payload = {out_red, out_green, out_blue, out_alpha, run_end, frame_end};

	// A stalled result stays offered.
	`CASF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

	// A stalled result keeps its payload.
	`CASF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload), "stalled result changed")

	// The final pixel of an image is always the last result of its item.
	`CASF_ASSERT_SAME(a_frame_end_run, out_valid && frame_end, run_end, "frame end without run end")

	// The second result of a last-row item follows its first one at once.
	`CASF_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !run_end, out_valid, "pair cut short")

endmodule

bind cross_average_smudge_filter_core casf_checker u_casf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_alpha (out_alpha),
	.run_end   (run_end),
	.frame_end (frame_end)
);
